### rtl/cordic_sc_pkg.sv
// Package: shared constants, types and the arctangent table for the CORDIC sine/cosine block.
package cordic_sc_pkg;

   // Field widths of the channels and the register
   localparam int ANGLE_W = 18;
   localparam int OUT_W   = 16;
   localparam int GAIN_W  = 14;

   // Datapath sizing
   localparam int ROTATIONS       = 13;
   localparam int DATA_WIDTH      = 16;
   localparam int ANGLE_FRAC_BITS = 8;
   localparam int TABLE_LEN       = 24;

   // Pipeline: angle reduction, angle scaling, one stage per rotation, output sign
   localparam int STAGES = ROTATIONS + 3;

   // Residual angle is kept in units of 1e-12 degree
   localparam longint unsigned PICO_PER_DEG = 64'd1000000000000;
   localparam longint unsigned PICO_PER_LSB = PICO_PER_DEG >> ANGLE_FRAC_BITS;

   // Reduced angle width: room for the input and for 360 degrees, plus sign and carry
   localparam int A_W = ((ANGLE_W > ANGLE_FRAC_BITS + 10) ? ANGLE_W : ANGLE_FRAC_BITS + 10) + 2;
   // Residual angle width: scaled angle plus headroom for the summed arctangents
   localparam int Z_W = A_W + $clog2(PICO_PER_LSB + 1) + 1;

   // Configuration port
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam logic [0:0] REG_GAIN_SEED = 1'b0;
   localparam logic [GAIN_W-1:0] GAIN_SEED_RESET = 14'd9949;

   typedef logic signed [ANGLE_W-1:0]    angle_type;
   typedef logic signed [OUT_W-1:0]      result_type;
   typedef logic        [GAIN_W-1:0]     gain_type;
   typedef logic signed [A_W-1:0]        wide_angle_type;
   typedef logic signed [DATA_WIDTH-1:0] data_type;
   typedef logic signed [Z_W-1:0]        resid_type;

   // atan(2^-j) in 1e-12 degree, rounded to nearest
   localparam longint ATAN_PDEG [TABLE_LEN] = '{
      64'sd45000000000000, 64'sd26565051177078, 64'sd14036243467926, 64'sd7125016348902,
      64'sd3576334374997,  64'sd1789910608246,  64'sd895173710211,   64'sd447614170861,
      64'sd223810500369,   64'sd111905677066,   64'sd55952891894,    64'sd27976452617,
      64'sd13988227142,    64'sd6994113675,     64'sd3497056851,     64'sd1748528427,
      64'sd874264214,      64'sd437132107,      64'sd218566053,      64'sd109283027,
      64'sd54641513,       64'sd27320757,       64'sd13660378,       64'sd6830189
   };

endpackage

### rtl/cordic_sc_req_if.sv
// Interface: angle request channel with valid/ready handshake.
interface cordic_sc_req_if;
   logic                      valid;
   logic                      ready;
   cordic_sc_pkg::angle_type  angle_deg;

   modport source (output valid, output angle_deg, input ready);
   modport sink   (input valid, input angle_deg, output ready);
endinterface

### rtl/cordic_sc_rsp_if.sv
// Interface: sine/cosine response channel with valid/ready handshake.
interface cordic_sc_rsp_if;
   logic                       valid;
   logic                       ready;
   cordic_sc_pkg::result_type  sine;
   cordic_sc_pkg::result_type  cosine;

   modport source (output valid, output sine, output cosine, input ready);
   modport sink   (input valid, input sine, input cosine, output ready);
endinterface

### rtl/cordic_sine_cosine.sv
// Top level: pipelined CORDIC rotation-mode sine/cosine of an angle in degrees.
//
//   channel   dir   handshake              payload
//   req_bus   in    valid/ready            angle_deg  s18, degrees, 8 fraction bits
//   rsp_bus   out   valid/ready            sine, cosine  s16, Q2.14
//   csr (APB) in    psel/penable/pwrite    gain_seed at byte address 0, u14
//
// One angle can transfer in every cycle while the response is not stalled; the pipeline has
// one register stage per micro-rotation plus reduction, scaling and sign stages.
// Each stage holds a valid bit; a stage advances when it is empty or the next one
// advances, so bubbles collapse and the block keeps taking angles while a result waits.
// A stalled response holds every full stage with no empty stage after it; nothing drops or repeats.
// Synchronous reset empties the pipeline and loads gain_seed with 9949 (about 0.6072).
module cordic_sine_cosine (
   input  logic                                  clock,
   input  logic                                  reset,
   cordic_sc_req_if.sink                         req_bus,
   cordic_sc_rsp_if.source                       rsp_bus,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [cordic_sc_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [cordic_sc_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [cordic_sc_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                                  pready
);

   localparam int NS  = cordic_sc_pkg::STAGES;
   localparam int ROT = cordic_sc_pkg::ROTATIONS;
   localparam int DW  = cordic_sc_pkg::DATA_WIDTH;
   localparam int AFB = cordic_sc_pkg::ANGLE_FRAC_BITS;

   // Reduction bounds in input LSBs
   localparam cordic_sc_pkg::wide_angle_type QUARTER_ANGLE =
      cordic_sc_pkg::wide_angle_type'(90 <<< AFB);
   localparam cordic_sc_pkg::wide_angle_type HALF_ANGLE =
      cordic_sc_pkg::wide_angle_type'(180 <<< AFB);
   localparam cordic_sc_pkg::wide_angle_type FULL_ANGLE =
      cordic_sc_pkg::wide_angle_type'(360 <<< AFB);
   // Scale from input LSB to 1e-12 degree
   localparam cordic_sc_pkg::resid_type PICO_Z =
      cordic_sc_pkg::resid_type'(cordic_sc_pkg::PICO_PER_LSB);

   // ---------------------------------------------------------------------------
   // Configuration register
   // ---------------------------------------------------------------------------
   cordic_sc_pkg::gain_type gain_seed_ff;
   logic                    reg_sel;

   assign reg_sel = (paddr[2] == cordic_sc_pkg::REG_GAIN_SEED);
   assign pready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_seed_ff <= cordic_sc_pkg::GAIN_SEED_RESET;
      end else if (psel && penable && pwrite && reg_sel) begin
         gain_seed_ff <= pwdata[cordic_sc_pkg::GAIN_W-1:0];
      end
   end

   // Reads of anything but the gain seed return zero
   always_comb begin
      prdata = '0;
      if (reg_sel) begin
         prdata = cordic_sc_pkg::CSR_DATA_W'(gain_seed_ff);
      end
   end

   // ---------------------------------------------------------------------------
   // Pipeline control: per-stage valid and advance
   // ---------------------------------------------------------------------------
   logic [NS-1:0] v_ff;
   logic [NS-1:0] en;

   // A stage advances when it is empty or its successor advances
   always_comb begin
      en[NS-1] = !v_ff[NS-1] || rsp_bus.ready;
      for (int i = NS - 2; i >= 0; i--) begin
         en[i] = !v_ff[i] || en[i+1];
      end
   end

   assign req_bus.ready = en[0];
   assign rsp_bus.valid = v_ff[NS-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[0]) begin
            v_ff[0] <= req_bus.valid;
         end
         for (int i = 1; i < NS; i++) begin
            if (en[i]) begin
               v_ff[i] <= v_ff[i-1];
            end
         end
      end
   end

   // Fold flag travels with each item up to the output stage
   logic [NS-2:0] neg_ff;

   // ---------------------------------------------------------------------------
   // Stage 0: wrap once by 360 into [-180,180], then fold beyond +-90 by 180
   // ---------------------------------------------------------------------------
   cordic_sc_pkg::wide_angle_type a_ext, a_wrap, angle_in, angle_ff;
   logic                          neg_in;

   always_comb begin
      a_ext = cordic_sc_pkg::wide_angle_type'(req_bus.angle_deg);
      if (a_ext > HALF_ANGLE) begin
         a_wrap = a_ext - FULL_ANGLE;
      end else if (a_ext < -HALF_ANGLE) begin
         a_wrap = a_ext + FULL_ANGLE;
      end else begin
         a_wrap = a_ext;
      end
      // Exactly +-90 stays; +-180 folds to zero with negation
      neg_in   = 1'b1;
      if (a_wrap > QUARTER_ANGLE) begin
         angle_in = a_wrap - HALF_ANGLE;
      end else if (a_wrap < -QUARTER_ANGLE) begin
         angle_in = a_wrap + HALF_ANGLE;
      end else begin
         angle_in = a_wrap;
         neg_in   = 1'b0;
      end
   end

   // ---------------------------------------------------------------------------
   // Stage 1: scale angle to 1e-12 degree and seed the vector at (gain_seed, 0)
   // Stages 2 .. ROT+1: one micro-rotation each, turning toward the residual angle
   // ---------------------------------------------------------------------------
   cordic_sc_pkg::data_type  x_ff [ROT+1];
   cordic_sc_pkg::data_type  y_ff [ROT+1];
   cordic_sc_pkg::resid_type z_ff [ROT+1];

   always_ff @(posedge clock) begin
      if (en[0]) begin
         angle_ff  <= angle_in;
         neg_ff[0] <= neg_in;
      end
      if (en[1]) begin
         z_ff[0]   <= cordic_sc_pkg::resid_type'(angle_ff) * PICO_Z;
         x_ff[0]   <= DW'(gain_seed_ff);
         y_ff[0]   <= '0;
         neg_ff[1] <= neg_ff[0];
      end
      // Arithmetic shifts floor, as required
      for (int j = 0; j < ROT; j++) begin
         if (en[j+2]) begin
            if (!z_ff[j][cordic_sc_pkg::Z_W-1]) begin
               x_ff[j+1] <= x_ff[j] - (y_ff[j] >>> j);
               y_ff[j+1] <= y_ff[j] + (x_ff[j] >>> j);
               z_ff[j+1] <= z_ff[j] - cordic_sc_pkg::resid_type'(cordic_sc_pkg::ATAN_PDEG[j]);
            end else begin
               x_ff[j+1] <= x_ff[j] + (y_ff[j] >>> j);
               y_ff[j+1] <= y_ff[j] - (x_ff[j] >>> j);
               z_ff[j+1] <= z_ff[j] + cordic_sc_pkg::resid_type'(cordic_sc_pkg::ATAN_PDEG[j]);
            end
            neg_ff[j+2] <= neg_ff[j+1];
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Last stage: undo the fold by negating both results, wrap at DATA_WIDTH
   // ---------------------------------------------------------------------------
   cordic_sc_pkg::data_type sine_ff, cosine_ff;

   always_ff @(posedge clock) begin
      if (en[NS-1]) begin
         if (neg_ff[NS-2]) begin
            sine_ff   <= -y_ff[ROT];
            cosine_ff <= -x_ff[ROT];
         end else begin
            sine_ff   <= y_ff[ROT];
            cosine_ff <= x_ff[ROT];
         end
      end
   end

   // Sign-extend or truncate to the port width
   assign rsp_bus.sine   = cordic_sc_pkg::OUT_W'(sine_ff);
   assign rsp_bus.cosine = cordic_sc_pkg::OUT_W'(cosine_ff);

   // ---------------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------------
   a_reset_empties: assert property (@(posedge clock) reset |=> !rsp_bus.valid)
      else $error("response valid right after reset");

   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      req_bus.valid && req_bus.ready |=> v_ff[0])
      else $error("transferred angle did not enter the first stage");

   a_empty_takes: assert property (@(posedge clock) disable iff (reset)
      !v_ff[0] |-> req_bus.ready)
      else $error("empty first stage refused a transfer");

   a_fold_range: assert property (@(posedge clock) disable iff (reset)
      v_ff[0] |-> (angle_ff <= QUARTER_ANGLE) && (angle_ff >= -QUARTER_ANGLE))
      else $error("reduced angle outside +-90 degrees");

endmodule

### tb/sv/cordic_sine_cosine_tb.sv
// Testbench: self-checking stimulus, scoreboard and flow control for the CORDIC sine/cosine block.
module cordic_sine_cosine_tb;

   // Register map and run limits
   localparam logic [cordic_sc_pkg::CSR_ADDR_W-1:0] GAIN_SEED_ADDR = 3'd0;  // register 0
   localparam logic [cordic_sc_pkg::CSR_ADDR_W-1:0] UNMAPPED_ADDR  = 3'd4;  // register 1
   localparam cordic_sc_pkg::gain_type GAIN_AT_RESET = 14'd9949;
   localparam int PIPE_LATENCY = 16;
   localparam int STALL_LIMIT  = 4000;   // cycles with no transfer before giving up
   localparam int LONG_HOLD    = 400;    // receiver hold-off, well past pipeline depth
   localparam int PHASE_ITEMS  = 350;

   typedef struct packed {
      cordic_sc_pkg::angle_type  angle;
      cordic_sc_pkg::result_type sine;
      cordic_sc_pkg::result_type cosine;
   } trig_expect_type;

   // Scoreboard: predicts sine/cosine for every accepted angle and checks results in order.
   class trig_scoreboard;
      trig_expect_type         expected_pairs[$];
      cordic_sc_pkg::gain_type gain = GAIN_AT_RESET;
      int                      errors = 0;

      // atan(2^-j) in units of 1e-12 degree
      static function longint atan_picodeg(int j);
         case (j)
            0:  return 64'sd45000000000000;
            1:  return 64'sd26565051177078;
            2:  return 64'sd14036243467926;
            3:  return 64'sd7125016348902;
            4:  return 64'sd3576334374997;
            5:  return 64'sd1789910608246;
            6:  return 64'sd895173710211;
            7:  return 64'sd447614170861;
            8:  return 64'sd223810500369;
            9:  return 64'sd111905677066;
            10: return 64'sd55952891894;
            11: return 64'sd27976452617;
            default: return 64'sd13988227142;
         endcase
      endfunction

      function void note_angle(cordic_sc_pkg::angle_type angle);
         longint                    a;
         longint                    z;
         cordic_sc_pkg::result_type x;
         cordic_sc_pkg::result_type y;
         cordic_sc_pkg::result_type xs;
         cordic_sc_pkg::result_type ys;
         bit                        flip;
         trig_expect_type           want;
         a = angle;
         flip = 1'b0;
         // one wrap by 360, then fold by 180 outside +-90
         if (a > 180 * 256)
            a -= 360 * 256;
         else if (a < -180 * 256)
            a += 360 * 256;
         if (a > 90 * 256) begin
            a -= 180 * 256;
            flip = 1'b1;
         end else if (a < -90 * 256) begin
            a += 180 * 256;
            flip = 1'b1;
         end
         z = (a * 64'sd1000000000000) / 64'sd256;
         x = cordic_sc_pkg::result_type'(gain);
         y = '0;
         for (int j = 0; j < 13; j++) begin
            xs = x >>> j;
            ys = y >>> j;
            if (z >= 0) begin
               x = x - ys;
               y = y + xs;
               z -= atan_picodeg(j);
            end else begin
               x = x + ys;
               y = y - xs;
               z += atan_picodeg(j);
            end
         end
         if (flip) begin
            x = -x;
            y = -y;
         end
         want.angle  = angle;
         want.sine   = y;
         want.cosine = x;
         expected_pairs.push_back(want);
      endfunction

      function void check_result(cordic_sc_pkg::result_type sine,
                                 cordic_sc_pkg::result_type cosine);
         trig_expect_type want;
         if (expected_pairs.size() == 0) begin
            errors++;
            $display("%0t: result with nothing expected: sine %0d cosine %0d",
                     $time, sine, cosine);
            return;
         end
         want = expected_pairs.pop_front();
         if (sine !== want.sine) begin
            errors++;
            $display("%0t: sine mismatch, angle %0d: expected %0d, actual %0d",
                     $time, want.angle, want.sine, sine);
         end
         if (cosine !== want.cosine) begin
            errors++;
            $display("%0t: cosine mismatch, angle %0d: expected %0d, actual %0d",
                     $time, want.angle, want.cosine, cosine);
         end
      endfunction
   endclass

   bit                                      clock;
   logic                                    reset;
   logic                                    psel;
   logic                                    penable;
   logic                                    pwrite;
   logic [cordic_sc_pkg::CSR_ADDR_W-1:0]    paddr;
   logic [cordic_sc_pkg::CSR_DATA_W-1:0]    pwdata;
   logic [cordic_sc_pkg::CSR_DATA_W-1:0]    prdata;
   logic                                    pready;

   cordic_sc_req_if req_bus ();
   cordic_sc_rsp_if rsp_bus ();

   cordic_sine_cosine DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   trig_scoreboard sb = new;

   // Flow-control knobs, percent of cycles spent idle on each side
   int src_idle_pct   = 0;
   int sink_stall_pct = 0;
   int hold_request   = 0;   // set by the stimulus, picked up by the receiver process

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // Receiver: drive ready at the falling edge; a requested hold-off is counted here
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request != 0) begin
            hold_left = hold_request;
            hold_request = 0;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_bus.ready = 1'b0;
         end else begin
            rsp_bus.ready = ($urandom_range(99) >= sink_stall_pct);
         end
      end
   end

   // Monitors: note each angle transfer and check each result transfer at the rising edge
   always @(posedge clock) begin
      if (!reset && req_bus.valid && req_bus.ready)
         sb.note_angle(req_bus.angle_deg);
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         sb.check_result(rsp_bus.sine, rsp_bus.cosine);
   end

   // Watchdog: end the run once no transfer has happened for too long
   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
             (psel && penable))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("Test completed with failures");
      $finish;
   end

   // Offer one angle after a random gap; return at the falling edge after its transfer.
   // Valid stays high on return so back-to-back angles keep it asserted.
   task automatic send_angle(input cordic_sc_pkg::angle_type angle);
      while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.valid = 1'b1;
      req_bus.angle_deg = angle;
      do
         @(posedge clock);
      while (!req_bus.ready);
      @(negedge clock);
   endtask

   // Drop valid and hold until every expected result has come back
   task automatic wait_drained();
      req_bus.valid = 1'b0;
      while (sb.expected_pairs.size() != 0)
         @(negedge clock);
   endtask

   // APB write: setup cycle, then access cycle until pready
   task automatic csr_write(input logic [cordic_sc_pkg::CSR_ADDR_W-1:0] addr,
                            input logic [cordic_sc_pkg::CSR_DATA_W-1:0] data);
      psel = 1'b1;
      penable = 1'b0;
      pwrite = 1'b1;
      paddr = addr;
      pwdata = data;
      @(negedge clock);
      penable = 1'b1;
      do
         @(posedge clock);
      while (!pready);
      if (addr == GAIN_SEED_ADDR)
         sb.gain = data[cordic_sc_pkg::GAIN_W-1:0];
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
   endtask

   // Mostly legal angles, some with every bit random, some hugging the fold
   // and wrap boundaries, some near zero.
   function automatic cordic_sc_pkg::angle_type random_angle();
      int pick;
      pick = $urandom_range(9);
      if (pick < 2)
         return cordic_sc_pkg::angle_type'($urandom);
      else if (pick < 7)
         return cordic_sc_pkg::angle_type'(int'($urandom_range(184320)) - 92160);
      else if (pick < 9)
         return cordic_sc_pkg::angle_type'((int'($urandom_range(8)) - 4) * 23040 +
                                           int'($urandom_range(4)) - 2);
      else
         return cordic_sc_pkg::angle_type'(int'($urandom_range(64)) - 32);
   endfunction

   // One stretch of random angles; optionally a long receiver hold-off or a
   // sender pause halfway through.
   task automatic run_random(input int count, input bit long_hold, input bit mid_pause);
      for (int i = 0; i < count; i++) begin
         if (i == count / 2) begin
            if (long_hold)
               hold_request = LONG_HOLD;
            if (mid_pause)
               wait_drained();
         end
         send_angle(random_angle());
      end
      wait_drained();
   endtask

   initial begin
      cordic_sc_pkg::angle_type corner_angles [20];
      corner_angles = '{
         18'sd0, 18'sd1, -18'sd1, 18'sd11520,               // zero, smallest steps, 45
         18'sd23040, -18'sd23040, 18'sd23041, -18'sd23041,  // exactly +-90 and just past
         18'sd46080, -18'sd46080, 18'sd46081, -18'sd46081,  // exactly +-180 and just past
         18'sd69120, -18'sd69120, 18'sd92160, -18'sd92160,  // +-270, +-360
         18'sd131071, -18'sd131072,                         // field extremes, past +-360
         18'h15555, 18'h2AAAA                               // alternating bit patterns
      };

      reset = 1'b1;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      req_bus.valid = 1'b0;
      req_bus.angle_deg = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Reset gain, no idling: corners first, pause for drain, then random traffic
      foreach (corner_angles[k])
         send_angle(corner_angles[k]);
      wait_drained();
      run_random(300, 1'b0, 1'b0);

      // Zero gain; a write to an unmapped address must be ignored. Sender idles.
      csr_write(GAIN_SEED_ADDR, 32'd0);
      csr_write(UNMAPPED_ADDR, 32'h0000_1234);
      src_idle_pct = 75;
      run_random(PHASE_ITEMS, 1'b0, 1'b1);

      // Largest gain, receiver stalls, with one long hold-off to fill the pipeline
      src_idle_pct = 0;
      sink_stall_pct = 75;
      csr_write(GAIN_SEED_ADDR, 32'd16383);
      run_random(PHASE_ITEMS, 1'b1, 1'b0);

      // Random gain, both sides idle
      src_idle_pct = 35;
      sink_stall_pct = 35;
      csr_write(GAIN_SEED_ADDR, 32'($urandom_range(1, 16382)));
      run_random(PHASE_ITEMS, 1'b0, 1'b0);

      // Back to the nominal gain at full rate, with another long hold-off
      src_idle_pct = 0;
      sink_stall_pct = 0;
      csr_write(GAIN_SEED_ADDR, 32'(GAIN_AT_RESET));
      run_random(PHASE_ITEMS, 1'b1, 1'b0);

      // Let any stray result surface before judging
      repeat (3 * PIPE_LATENCY) @(posedge clock);
      if (sb.errors == 0 && sb.expected_pairs.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
